// ===== src/cbt_pkg.sv =====
// ----------------------------------------------------------------------------
// cbt_pkg
// Shared widths, constants and types of the cubic Bezier tessellator.
// ----------------------------------------------------------------------------
package cbt_pkg;

	localparam int COORD_W = 16;
	localparam int IDX_W   = 6;
	localparam int FRAC_W  = 16;            // t and u are Q0.16 in pt_t
	localparam int WT_W    = 49;            // Bernstein weights, Q.48, up to 2^48
	localparam int PROD_W  = 64;            // weight times offset coordinate
	localparam int SUM_W   = 66;

	localparam logic [IDX_W-1:0]    MAX_SEGMENTS  = 6'd63;
	localparam logic [IDX_W-1:0]    SEG_RESET     = 6'd16;
	localparam logic [WT_W-1:0]     WT_ONE        = 49'h1_0000_0000_0000;
	localparam logic [COORD_W-1:0]  COORD_OFFSET  = 16'h8000;
	localparam logic [FRAC_W:0]     T_ONE         = 17'h1_0000;

	// sequencer states
	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_DIV,
		SEQ_EMIT
	} seq_state_t;

	// per-point tag carried alongside the datapath
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             last;
	} meta_t;

	// one curve parameter issued by the sequencer
	typedef struct packed {
		logic [FRAC_W-1:0] t;
		logic [FRAC_W-1:0] u;
		logic              first;
		meta_t             meta;
	} pt_t;

	// the four Bernstein weights of one point
	typedef struct packed {
		logic [WT_W-1:0] w0;
		logic [WT_W-1:0] w1;
		logic [WT_W-1:0] w2;
		logic [WT_W-1:0] w3;
	} weights_t;

endpackage

// ===== src/cbt_point_seq.sv =====
// ----------------------------------------------------------------------------
// cbt_point_seq
// Works out 65536/n by restoring division, then steps t = floor(i*65536/n)
// for i = 0..n with a quotient add and a remainder carry, one point a cycle while adv is high.
// ----------------------------------------------------------------------------
module cbt_point_seq import cbt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [IDX_W-1:0] n,
	input  logic             adv,
	output logic             idle,
	output logic             pt_valid,
	output pt_t              pt
);

	seq_state_t state_q, state_d;

	logic [IDX_W-1:0]  n_q;
	logic [IDX_W-1:0]  rem_q;
	logic [FRAC_W:0]   quo_q;
	logic [4:0]        cnt_q;
	logic [IDX_W-1:0]  idx_q;
	logic [FRAC_W:0]   t_q;
	logic [IDX_W-1:0]  acc_q;

	logic [IDX_W:0]    part;
	logic              part_ge;
	logic [IDX_W:0]    acc_sum;
	logic              acc_carry;

	// division step: numerator is 2^16, so only its top bit is set
	assign part    = {rem_q, (cnt_q == 5'd16)};
	assign part_ge = part >= {1'b0, n_q};

	// remainder accumulation for the next t
	assign acc_sum   = {1'b0, acc_q} + {1'b0, rem_q};
	assign acc_carry = acc_sum >= {1'b0, n_q};

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and outputs
	always_comb begin
		state_d  = state_q;
		idle     = 1'b0;
		pt_valid = 1'b0;
		case (state_q)
			SEQ_IDLE: begin
				idle = 1'b1;
				if (start) state_d = SEQ_DIV;
			end
			SEQ_DIV: begin
				if (cnt_q == 5'd0) state_d = SEQ_EMIT;
			end
			SEQ_EMIT: begin
				pt_valid = 1'b1;
				if (adv && idx_q == n_q) state_d = SEQ_IDLE;
			end
			default: begin
				state_d = SEQ_IDLE;
			end
		endcase
	end

	// divider and t stepping datapath
	always_ff @(posedge clk) begin
		if (state_q == SEQ_IDLE && start) begin
			n_q   <= n;
			rem_q <= '0;
			quo_q <= '0;
			cnt_q <= 5'd16;
		end else if (state_q == SEQ_DIV) begin
			rem_q <= part_ge ? IDX_W'(part - {1'b0, n_q}) : part[IDX_W-1:0];
			quo_q <= {quo_q[FRAC_W-1:0], part_ge};
			cnt_q <= cnt_q - 5'd1;
			idx_q <= '0;
			t_q   <= '0;
			acc_q <= '0;
		end else if (state_q == SEQ_EMIT && adv) begin
			idx_q <= idx_q + IDX_W'(1);
			acc_q <= acc_carry ? IDX_W'(acc_sum - {1'b0, n_q}) : acc_sum[IDX_W-1:0];
			t_q   <= t_q + quo_q + {{FRAC_W{1'b0}}, acc_carry};
		end
	end

	// point handed to the weight pipeline
	always_comb begin
		pt.t         = t_q[FRAC_W-1:0];
		pt.u         = FRAC_W'(T_ONE - t_q);
		pt.first     = (idx_q == '0);
		pt.meta.idx  = idx_q;
		pt.meta.last = (idx_q == n_q);
	end

endmodule

// ===== src/cbt_weight.sv =====
// ----------------------------------------------------------------------------
// cbt_weight
// Three-stage pipeline that turns t and u into the Bernstein weights
// u^3, 3u^2t, 3ut^2 and t^3 in Q.48, shared by both coordinate lanes.
// ----------------------------------------------------------------------------
module cbt_weight import cbt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     adv,
	input  logic     pt_valid,
	input  pt_t      pt,
	output logic     wt_valid,
	output weights_t wts,
	output meta_t    meta,
	output logic     busy
);

	localparam int SQ_W  = 2 * FRAC_W;
	localparam int CUB_W = 3 * FRAC_W;

	logic v_s1, v_s2, v_s3;

	logic [SQ_W-1:0]   uu_s1, tt_s1;
	logic [FRAC_W-1:0] t_s1, u_s1;
	logic              first_s1, first_s2;
	meta_t             meta_s1, meta_s2, meta_s3;

	logic [CUB_W-1:0]  uuu_s2, uut_s2, utt_s2, ttt_s2;
	weights_t          wts_s3;

	logic [WT_W:0]     w1_x3, w2_x3;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pt_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: squares
	always_ff @(posedge clk) begin
		if (adv) begin
			uu_s1    <= SQ_W'(pt.u) * SQ_W'(pt.u);
			tt_s1    <= SQ_W'(pt.t) * SQ_W'(pt.t);
			t_s1     <= pt.t;
			u_s1     <= pt.u;
			first_s1 <= pt.first;
			meta_s1  <= pt.meta;
		end
	end

	// stage 2: cubes and mixed terms
	always_ff @(posedge clk) begin
		if (adv) begin
			uuu_s2   <= CUB_W'(uu_s1) * CUB_W'(u_s1);
			uut_s2   <= CUB_W'(uu_s1) * CUB_W'(t_s1);
			utt_s2   <= CUB_W'(tt_s1) * CUB_W'(u_s1);
			ttt_s2   <= CUB_W'(tt_s1) * CUB_W'(t_s1);
			first_s2 <= first_s1;
			meta_s2  <= meta_s1;
		end
	end

	// times three by shift and add
	assign w1_x3 = (WT_W+1)'(uut_s2) + ((WT_W+1)'(uut_s2) << 1);
	assign w2_x3 = (WT_W+1)'(utt_s2) + ((WT_W+1)'(utt_s2) << 1);

	// stage 3: final weights, endpoints forced to a single unit weight
	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s3 <= meta_s2;
			if (first_s2) begin
				wts_s3.w0 <= WT_ONE;
				wts_s3.w1 <= '0;
				wts_s3.w2 <= '0;
				wts_s3.w3 <= '0;
			end else if (meta_s2.last) begin
				wts_s3.w0 <= '0;
				wts_s3.w1 <= '0;
				wts_s3.w2 <= '0;
				wts_s3.w3 <= WT_ONE;
			end else begin
				wts_s3.w0 <= WT_W'(uuu_s2);
				wts_s3.w1 <= w1_x3[WT_W-1:0];
				wts_s3.w2 <= w2_x3[WT_W-1:0];
				wts_s3.w3 <= WT_W'(ttt_s2);
			end
		end
	end

	assign wt_valid = v_s3;
	assign wts      = wts_s3;
	assign meta     = meta_s3;
	assign busy     = v_s1 | v_s2 | v_s3;

endmodule

// ===== src/cbt_lane.sv =====
// ----------------------------------------------------------------------------
// cbt_lane
// One coordinate lane: holds the four control coordinates of the segment,
// multiplies them by the weights, sums and rounds to a Q1.14 coordinate.
// ----------------------------------------------------------------------------
module cbt_lane import cbt_pkg::*; (
	input  logic                      clk,
	input  logic                      load,
	input  logic signed [COORD_W-1:0] c0,
	input  logic signed [COORD_W-1:0] c1,
	input  logic signed [COORD_W-1:0] c2,
	input  logic signed [COORD_W-1:0] c3,
	input  logic                      adv,
	input  weights_t                  wts,
	output logic signed [COORD_W-1:0] coord
);

	localparam int RES_W = SUM_W - (WT_W - 1);

	logic [COORD_W-1:0] q0_q, q1_q, q2_q, q3_q;
	logic [PROD_W-1:0]  m0_s4, m1_s4, m2_s4, m3_s4;
	logic [PROD_W:0]    s01_s5, s23_s5;
	logic [SUM_W-1:0]   total;
	logic [RES_W-1:0]   rounded;
	logic [COORD_W-1:0] sat;

	// control coordinates, offset to unsigned
	always_ff @(posedge clk) begin
		if (load) begin
			q0_q <= c0 ^ COORD_OFFSET;
			q1_q <= c1 ^ COORD_OFFSET;
			q2_q <= c2 ^ COORD_OFFSET;
			q3_q <= c3 ^ COORD_OFFSET;
		end
	end

	// stage 4: weighted coordinates
	always_ff @(posedge clk) begin
		if (adv) begin
			m0_s4 <= PROD_W'(PROD_W'(wts.w0) * PROD_W'(q0_q));
			m1_s4 <= PROD_W'(PROD_W'(wts.w1) * PROD_W'(q1_q));
			m2_s4 <= PROD_W'(PROD_W'(wts.w2) * PROD_W'(q2_q));
			m3_s4 <= PROD_W'(PROD_W'(wts.w3) * PROD_W'(q3_q));
		end
	end

	// stage 5: pair sums
	always_ff @(posedge clk) begin
		if (adv) begin
			s01_s5 <= (PROD_W+1)'(m0_s4) + (PROD_W+1)'(m1_s4);
			s23_s5 <= (PROD_W+1)'(m2_s4) + (PROD_W+1)'(m3_s4);
		end
	end

	// round half up, saturate, back to two's complement
	assign total   = SUM_W'(s01_s5) + SUM_W'(s23_s5) + (SUM_W'(1) << (WT_W - 2));
	assign rounded = total[SUM_W-1:WT_W-1];
	assign sat     = (rounded > RES_W'({COORD_W{1'b1}})) ? {COORD_W{1'b1}}
	                                                       : rounded[COORD_W-1:0];
	assign coord   = sat ^ COORD_OFFSET;

endmodule

// ===== src/cubic_bezier_tessellator_unit.sv =====
// ----------------------------------------------------------------------------
// cubic_bezier_tessellator_unit
// Evaluates a cubic Bezier segment at n+1 evenly spaced points.
// ----------------------------------------------------------------------------
// A segment word (four Q1.14 control points) yields n+1 point words, n being
// segment_count with 0 read as 1. After a word is taken the sequencer runs
// the bit-serial 65536/n division, then issues one point per cycle while the
// output is not stalled into a six-stage pipeline (three weight stages, two
// lane stages, the output register). The next segment is taken once the
// sequencer is idle and the weight stages are empty. segment_count resets
// to 16 and may be written only between segments.
// ----------------------------------------------------------------------------
module cubic_bezier_tessellator_unit import cbt_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [IDX_W-1:0]          cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [COORD_W-1:0] p0_x,
	input  logic signed [COORD_W-1:0] p0_y,
	input  logic signed [COORD_W-1:0] p1_x,
	input  logic signed [COORD_W-1:0] p1_y,
	input  logic signed [COORD_W-1:0] p2_x,
	input  logic signed [COORD_W-1:0] p2_y,
	input  logic signed [COORD_W-1:0] p3_x,
	input  logic signed [COORD_W-1:0] p3_y,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [COORD_W-1:0] point_x,
	output logic signed [COORD_W-1:0] point_y,
	output logic [IDX_W-1:0]          point_number,
	output logic                      last_point
);

	logic [IDX_W-1:0] segment_count_q;
	logic [IDX_W-1:0] n_eff;
	logic             adv;
	logic             in_accept;
	logic             seq_idle;
	logic             pt_valid;
	pt_t              pt;
	logic             wt_valid;
	weights_t         wts;
	meta_t            wt_meta;
	logic             wt_busy;
	logic             v_s4, v_s5;
	meta_t            meta_s4, meta_s5;
	logic signed [COORD_W-1:0] lane_x, lane_y;
	logic             out_valid_q;
	logic signed [COORD_W-1:0] point_x_q, point_y_q;
	meta_t            out_meta_q;

	// segment count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segment_count_q <= SEG_RESET;
		end else if (cfg_wr_en) begin
			segment_count_q <= cfg_wr_data;
		end
	end

	// effective count, zero read as one
	always_comb begin
		n_eff = segment_count_q;
		if (n_eff == '0) n_eff = IDX_W'(1);
		if (n_eff > MAX_SEGMENTS) n_eff = MAX_SEGMENTS;
	end

	// pipeline moves whenever the output register can take a word
	assign adv       = !out_valid_q || !out_stall;
	assign in_stall  = !(seq_idle && !wt_busy);
	assign in_accept = in_valid && !in_stall;

	cbt_point_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_accept),
		.n        (n_eff),
		.adv      (adv),
		.idle     (seq_idle),
		.pt_valid (pt_valid),
		.pt       (pt)
	);

	cbt_weight u_weight (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.pt_valid (pt_valid),
		.pt       (pt),
		.wt_valid (wt_valid),
		.wts      (wts),
		.meta     (wt_meta),
		.busy     (wt_busy)
	);

	// x and y lanes
	cbt_lane u_lane_x (
		.clk   (clk),
		.load  (in_accept),
		.c0    (p0_x),
		.c1    (p1_x),
		.c2    (p2_x),
		.c3    (p3_x),
		.adv   (adv),
		.wts   (wts),
		.coord (lane_x)
	);

	cbt_lane u_lane_y (
		.clk   (clk),
		.load  (in_accept),
		.c0    (p0_y),
		.c1    (p1_y),
		.c2    (p2_y),
		.c3    (p3_y),
		.adv   (adv),
		.wts   (wts),
		.coord (lane_y)
	);

	// valid bits alongside the lane stages and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s4        <= wt_valid;
			v_s5        <= v_s4;
			out_valid_q <= v_s5;
		end
	end

	// point tags alongside the lanes, merged with lane results into the output word
	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s4 <= wt_meta;
			meta_s5 <= meta_s4;
			if (v_s5) begin
				point_x_q  <= lane_x;
				point_y_q  <= lane_y;
				out_meta_q <= meta_s5;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign point_x      = point_x_q;
	assign point_y      = point_y_q;
	assign point_number = out_meta_q.idx;
	assign last_point   = out_meta_q.last;

endmodule

// ===== tb/cubic_bezier_tessellator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// cubic_bezier_tessellator_unit_tb
// Self-checking bench for the cubic Bezier tessellator. Segment words are
// queued by a stimulus process and offered by a clocked driver. Every
// accepted segment is expanded by a fixed-point Bernstein evaluator into the
// point words it must produce. A clocked monitor compares each point word
// field by field with the oldest prediction. The run sweeps segment counts,
// including zero and the maximum, under several idle and stall mixes, one
// long output hold-off and mid-phase sender pauses.
// ----------------------------------------------------------------------------
module cubic_bezier_tessellator_unit_tb import cbt_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_PRINTS = 40;

	typedef struct packed {
		logic [COORD_W-1:0] p0_x;
		logic [COORD_W-1:0] p0_y;
		logic [COORD_W-1:0] p1_x;
		logic [COORD_W-1:0] p1_y;
		logic [COORD_W-1:0] p2_x;
		logic [COORD_W-1:0] p2_y;
		logic [COORD_W-1:0] p3_x;
		logic [COORD_W-1:0] p3_y;
	} segment_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [IDX_W-1:0]   num;
		logic               last;
	} curve_point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [IDX_W-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [COORD_W-1:0] p0_x = '0;
	logic signed [COORD_W-1:0] p0_y = '0;
	logic signed [COORD_W-1:0] p1_x = '0;
	logic signed [COORD_W-1:0] p1_y = '0;
	logic signed [COORD_W-1:0] p2_x = '0;
	logic signed [COORD_W-1:0] p2_y = '0;
	logic signed [COORD_W-1:0] p3_x = '0;
	logic signed [COORD_W-1:0] p3_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic [IDX_W-1:0] point_number;
	logic last_point;

	segment_t segment_queue[$];
	curve_point_t expected_points[$];
	segment_t offered_seg;
	logic [IDX_W-1:0] seg_count = SEG_RESET;
	int send_idle_pct = 0;
	int stall_pct = 0;
	bit send_hold = 1'b0;
	bit hold_off = 1'b0;
	int err_cnt = 0;
	int cycle_cnt = 0;

	cubic_bezier_tessellator_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.p0_x         (p0_x),
		.p0_y         (p0_y),
		.p1_x         (p1_x),
		.p1_y         (p1_y),
		.p2_x         (p2_x),
		.p2_y         (p2_y),
		.p3_x         (p3_x),
		.p3_y         (p3_y),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_number (point_number),
		.last_point   (last_point)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// one coordinate of B(t): offset to unsigned, weigh, round half up, saturate
	function automatic logic [COORD_W-1:0] weigh_coord(logic [65:0] w0, logic [65:0] w1,
			logic [65:0] w2, logic [65:0] w3, logic [COORD_W-1:0] a, logic [COORD_W-1:0] b,
			logic [COORD_W-1:0] c, logic [COORD_W-1:0] d);
		logic [65:0] acc;
		logic [65:0] rnd;
		acc = w0 * 66'(a ^ COORD_OFFSET) + w1 * 66'(b ^ COORD_OFFSET)
			+ w2 * 66'(c ^ COORD_OFFSET) + w3 * 66'(d ^ COORD_OFFSET);
		rnd = (acc + (66'd1 << 47)) >> 48;
		if (rnd > 66'hFFFF) rnd = 66'hFFFF;
		return rnd[COORD_W-1:0] ^ COORD_OFFSET;
	endfunction

	// expand one segment word into its n+1 expected point words
	function automatic void tessellate_segment(segment_t s);
		int n;
		logic [65:0] t, u, w0, w1, w2, w3;
		curve_point_t pt;
		n = (seg_count == 0) ? 1 : int'(seg_count);
		if (n > int'(MAX_SEGMENTS)) n = int'(MAX_SEGMENTS);
		for (int i = 0; i <= n; i++) begin
			t = (66'(i) << 16) / 66'(n);
			u = 66'd65536 - t;
			w0 = u * u * u;
			w1 = 66'd3 * u * u * t;
			w2 = 66'd3 * u * t * t;
			w3 = t * t * t;
			pt.x = weigh_coord(w0, w1, w2, w3, s.p0_x, s.p1_x, s.p2_x, s.p3_x);
			pt.y = weigh_coord(w0, w1, w2, w3, s.p0_y, s.p1_y, s.p2_y, s.p3_y);
			pt.num = IDX_W'(i);
			pt.last = (i == n);
			expected_points.insert(expected_points.size(), pt);
		end
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		if (err_cnt < MAX_PRINTS)
			$display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		err_cnt++;
	endtask

	// driver: predict on acceptance, then offer the next queued segment word
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) tessellate_segment(offered_seg);
			if (!in_valid || !in_stall) begin
				if (segment_queue.size() != 0 && !send_hold
						&& $urandom_range(99) >= send_idle_pct) begin
					offered_seg = segment_queue.pop_front();
					p0_x <= offered_seg.p0_x;
					p0_y <= offered_seg.p0_y;
					p1_x <= offered_seg.p1_x;
					p1_y <= offered_seg.p1_y;
					p2_x <= offered_seg.p2_x;
					p2_y <= offered_seg.p2_y;
					p3_x <= offered_seg.p3_x;
					p3_y <= offered_seg.p3_y;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check point words, drive random stall and the long hold-off
	always @(posedge clk) begin
		curve_point_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_points.size() == 0) begin
				report_mismatch("unexpected point word, number", int'(point_number), -1);
			end else begin
				want = expected_points.pop_front();
				if (point_x !== want.x)
					report_mismatch("point_x", int'(point_x), int'($signed(want.x)));
				if (point_y !== want.y)
					report_mismatch("point_y", int'(point_y), int'($signed(want.y)));
				if (point_number !== want.num)
					report_mismatch("point_number", int'(point_number), int'(want.num));
				if (last_point !== want.last)
					report_mismatch("last_point", int'(last_point), int'(want.last));
			end
		end
		out_stall <= hold_off || ($urandom_range(99) < stall_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic logic [COORD_W-1:0] random_coord();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			default: return COORD_W'($urandom);
		endcase
	endfunction

	function automatic segment_t random_segment();
		segment_t s;
		s.p0_x = random_coord();
		s.p0_y = random_coord();
		s.p1_x = random_coord();
		s.p1_y = random_coord();
		s.p2_x = random_coord();
		s.p2_y = random_coord();
		s.p3_x = random_coord();
		s.p3_y = random_coord();
		return s;
	endfunction

	function automatic segment_t make_segment(logic [COORD_W-1:0] x0, logic [COORD_W-1:0] y0,
			logic [COORD_W-1:0] x1, logic [COORD_W-1:0] y1, logic [COORD_W-1:0] x2,
			logic [COORD_W-1:0] y2, logic [COORD_W-1:0] x3, logic [COORD_W-1:0] y3);
		segment_t s;
		s = '{x0, y0, x1, y1, x2, y2, x3, y3};
		return s;
	endfunction

	// append one segment word to the pending queue
	function automatic void queue_segment(segment_t s);
		segment_queue.insert(segment_queue.size(), s);
	endfunction

	// wait until no word is queued, offered or expected
	task automatic wait_drained();
		do @(negedge clk);
		while (segment_queue.size() != 0 || in_valid || expected_points.size() != 0);
	endtask

	// register write, only while the block is idle
	task automatic write_segment_count(logic [IDX_W-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		seg_count = value;
		@(negedge clk);
	endtask

	// one random phase; optionally pause the sender halfway until all points arrive
	task automatic run_phase(int count_val, int s_pct, int r_pct, int items, bit pause_mid);
		write_segment_count(IDX_W'(count_val));
		send_idle_pct = s_pct;
		stall_pct = r_pct;
		for (int k = 0; k < items; k++) queue_segment(random_segment());
		if (pause_mid) begin
			do @(negedge clk);
			while (segment_queue.size() > items / 2);
			send_hold = 1'b1;
			do @(negedge clk);
			while (in_valid || expected_points.size() != 0);
			send_hold = 1'b0;
		end
		wait_drained();
	endtask

	// stimulus
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed words at the reset count of 16
		queue_segment(make_segment(16'h8000, 16'h8000, 16'h8000, 16'h8000,
			16'h8000, 16'h8000, 16'h8000, 16'h8000));
		queue_segment(make_segment(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
			16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
		queue_segment('0);
		queue_segment(make_segment(16'h8000, 16'h7FFF, 16'h0000, 16'h0000,
			16'h0000, 16'h0000, 16'h7FFF, 16'h8000));
		queue_segment(make_segment(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
			16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF));
		queue_segment(make_segment(16'h0000, 16'h0000, 16'h7FFF, 16'h8000,
			16'h8000, 16'h7FFF, 16'h0000, 16'h0000));
		queue_segment(make_segment(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
			16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
		queue_segment(make_segment(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
			16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
		wait_drained();

		// zero count reads as one segment
		write_segment_count(6'd0);
		queue_segment(make_segment(16'h8000, 16'h7FFF, 16'h1234, 16'hEDCB,
			16'h4000, 16'hC000, 16'h7FFF, 16'h8000));
		queue_segment(make_segment(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
			16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
		queue_segment(random_segment());
		wait_drained();

		// maximum count
		write_segment_count(MAX_SEGMENTS);
		queue_segment(make_segment(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
			16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF));
		queue_segment(make_segment(16'h4000, 16'hC000, 16'h7FFF, 16'h8000,
			16'h8000, 16'h7FFF, 16'hC000, 16'h4000));
		queue_segment(random_segment());
		wait_drained();

		// single segment
		write_segment_count(6'd1);
		queue_segment(make_segment(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
			16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF));
		queue_segment(random_segment());
		wait_drained();

		// random phases across idle and stall mixes
		run_phase(1, 0, 0, 30, 1'b0);
		run_phase(int'(MAX_SEGMENTS), 0, 0, 15, 1'b1);
		run_phase($urandom_range(2, 62), 72, 0, 40, 1'b0);
		run_phase($urandom_range(2, 62), 0, 72, 40, 1'b1);
		run_phase($urandom_range(2, 62), 34, 34, 40, 1'b0);

		// long output hold-off while the sender keeps offering words
		write_segment_count(MAX_SEGMENTS);
		send_idle_pct = 0;
		stall_pct = 0;
		for (int k = 0; k < 25; k++) queue_segment(random_segment());
		fork
			begin
				hold_off = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off = 1'b0;
			end
		join_none
		wait_drained();

		run_phase(0, 34, 34, 20, 1'b0);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0 && expected_points.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/cbt_pkg.sv
src/cbt_point_seq.sv
src/cbt_weight.sv
src/cbt_lane.sv
src/cubic_bezier_tessellator_unit.sv
tb/cubic_bezier_tessellator_unit_tb.sv
